// ===== design/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// Regression tree inference package
// Shared constants, stream field layout and controller/datapath interface
// types for the regression tree inference unit.
// ----------------------------------------------------------------------------
package rti_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int DEF_TREE_DEPTH   = 6;
  localparam int DEF_NUM_FEATURES = 256;

  // Fixed field widths of the stream items.
  localparam int OP_W        = 2;
  localparam int NODE_IDX_W  = 7;
  localparam int VALUE_W     = 32;
  localparam int LEVEL_W     = 3;
  localparam int FEAT_ID_W   = 8;

  // Current-node register: a child of the last writable node still fits.
  localparam int CUR_W = NODE_IDX_W + 2;

  // Input tdata layout, lowest bit first.
  localparam int IN_NODE_IDX_LSB  = 0;
  localparam int IN_IS_LEAF_LSB   = IN_NODE_IDX_LSB + NODE_IDX_W;
  localparam int IN_SPLIT_LSB     = IN_IS_LEAF_LSB + 1;
  localparam int IN_OUTPUT_LSB    = IN_SPLIT_LSB + VALUE_W;
  localparam int IN_LEVEL_LSB     = IN_OUTPUT_LSB + VALUE_W;
  localparam int IN_LVL_FEAT_LSB  = IN_LEVEL_LSB + LEVEL_W;
  localparam int IN_ELEM_IDX_LSB  = IN_LVL_FEAT_LSB + FEAT_ID_W;
  localparam int IN_ELEM_VAL_LSB  = IN_ELEM_IDX_LSB + FEAT_ID_W;
  localparam int IN_USED_W        = IN_ELEM_VAL_LSB + VALUE_W;
  localparam int IN_TDATA_W       = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int OUT_USED_W  = VALUE_W + NODE_IDX_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Item kinds carried in tuser.
  typedef enum logic [OP_W-1:0] {
    OP_NODE   = 2'd0,
    OP_LEVEL  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;    // an input item is taken this cycle
    logic init;      // start a walk from the root
    logic step;      // compare data is ready, move to a child
    logic load_out;  // capture the reached leaf into the output register
  } rti_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic start_req; // offered item is a sample element marked last
    logic walk_done; // current node ends the walk
  } rti_stat_t;

endpackage

// ===== design/regression_tree_inference_unit.sv =====
// ----------------------------------------------------------------------------
// Regression tree inference unit
// Walks a heap-ordered binary regression tree over a loaded sample and
// returns the output value and index of the leaf it reaches.
// ----------------------------------------------------------------------------
// Node entries, per-level feature ids and sample elements each arrive as one
// input item and are taken one per cycle whenever the unit is idle, even
// while a finished result still waits on the output. A sample element marked
// last starts the walk from the root after its own value is stored. Each
// internal node passes a fetch step, which reads the level's feature value
// and the node's split from their synchronous stores, and a compare step,
// which picks the child. At most TREE_DEPTH internal nodes are passed.
// No input item is taken from the start of the walk until the reached leaf
// is loaded into the output register. Values are signed Q16.16
// and are only compared, never rounded. Unwritten node, level or sample
// entries read back as arbitrary data; node leaf flags start set after reset.
module regression_tree_inference_unit #(
  parameter int TREE_DEPTH   = rti_pkg::DEF_TREE_DEPTH,
  parameter int NUM_FEATURES = rti_pkg::DEF_NUM_FEATURES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input item stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // From bit 0: node_index[7], node_is_leaf[1], node_split[32],
  // node_output[32], level[3], level_feature[8], element_index[8],
  // element_value[32], zero padding[5].
  input  logic [rti_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // op[2]: 0 node entry, 1 level feature id, 2 sample element.
  input  logic [rti_pkg::OP_W-1:0]        s_axis_tuser,
  // last_element: final sample element, starts the walk.
  input  logic                            s_axis_tlast,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // From bit 0: prediction[32], leaf_node[7], zero padding[1].
  output logic [rti_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import rti_pkg::*;

  rti_cmd_t  cmd;
  rti_stat_t stat;

  // The controller decides when items are taken and results shown.
  rti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  // The datapath holds the tree, the sample and the walk state.
  rti_datapath #(
    .TREE_DEPTH   (TREE_DEPTH),
    .NUM_FEATURES (NUM_FEATURES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ===== design/rti_ctrl.sv =====
// ----------------------------------------------------------------------------
// Regression tree inference controller
// Sequences the tree walk and owns the handshake and output valid state.
// ----------------------------------------------------------------------------
module rti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              m_ready_i,
  input  rti_pkg::rti_stat_t stat_i,
  output rti_pkg::rti_cmd_t  cmd_o,
  output logic              in_ready_o,
  output logic              out_valid_o
);
  import rti_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e state_d, state_q;
  logic   out_valid_d, out_valid_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = s_valid_i & in_ready_o;

  always_comb begin
    cmd_o.accept   = accept;
    cmd_o.init     = accept & stat_i.start_req;
    cmd_o.step     = (state_q == ST_CMP);
    cmd_o.load_out = (state_q == ST_OUT) & (~out_valid_q | m_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (cmd_o.init) state_d = ST_FETCH;
      ST_FETCH: state_d = stat_i.walk_done ? ST_OUT : ST_CMP;
      ST_CMP:   state_d = ST_FETCH;
      ST_OUT:   if (cmd_o.load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~m_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/rti_datapath.sv =====
// ----------------------------------------------------------------------------
// Regression tree inference datapath
// Node, level and sample stores, the walk registers, the signed split
// compare and the output payload register.
// ----------------------------------------------------------------------------
module rti_datapath #(
  parameter int TREE_DEPTH   = rti_pkg::DEF_TREE_DEPTH,
  parameter int NUM_FEATURES = rti_pkg::DEF_NUM_FEATURES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rti_pkg::OP_W-1:0]       op_i,
  input  logic [rti_pkg::IN_TDATA_W-1:0] in_data_i,
  input  logic                           last_i,
  input  rti_pkg::rti_cmd_t              cmd_i,
  output rti_pkg::rti_stat_t             stat_o,
  output logic [rti_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import rti_pkg::*;

  localparam int NUM_NODES = (1 << (TREE_DEPTH + 1)) - 1;
  localparam int NODE_CNT  = (NUM_NODES < (1 << NODE_IDX_W)) ? NUM_NODES
                                                             : (1 << NODE_IDX_W);
  localparam int NODE_AW   = $clog2(NODE_CNT);
  localparam int FEAT_CNT  = (NUM_FEATURES < (1 << FEAT_ID_W)) ? NUM_FEATURES
                                                               : (1 << FEAT_ID_W);
  localparam int FEAT_AW   = (FEAT_CNT > 1) ? $clog2(FEAT_CNT) : 1;
  localparam int LVL_AW    = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
  localparam int DEP_W     = $clog2(TREE_DEPTH + 1);

  // Field views of the input item.
  logic [NODE_IDX_W-1:0] node_idx;
  logic                  node_leaf;
  logic [VALUE_W-1:0]    node_split;
  logic [VALUE_W-1:0]    node_out;
  logic [LEVEL_W-1:0]    level;
  logic [FEAT_ID_W-1:0]  level_feat;
  logic [FEAT_ID_W-1:0]  elem_idx;
  logic [VALUE_W-1:0]    elem_val;

  assign node_idx   = in_data_i[IN_NODE_IDX_LSB +: NODE_IDX_W];
  assign node_leaf  = in_data_i[IN_IS_LEAF_LSB];
  assign node_split = in_data_i[IN_SPLIT_LSB +: VALUE_W];
  assign node_out   = in_data_i[IN_OUTPUT_LSB +: VALUE_W];
  assign level      = in_data_i[IN_LEVEL_LSB +: LEVEL_W];
  assign level_feat = in_data_i[IN_LVL_FEAT_LSB +: FEAT_ID_W];
  assign elem_idx   = in_data_i[IN_ELEM_IDX_LSB +: FEAT_ID_W];
  assign elem_val   = in_data_i[IN_ELEM_VAL_LSB +: VALUE_W];

  logic node_we, level_we, elem_we;

  assign node_we  = cmd_i.accept && (op_i == OP_NODE) &&
                    (32'(node_idx) < 32'(NODE_CNT));
  assign level_we = cmd_i.accept && (op_i == OP_LEVEL) &&
                    (32'(level) < 32'(TREE_DEPTH));
  assign elem_we  = cmd_i.accept && (op_i == OP_SAMPLE) &&
                    (32'(elem_idx) < 32'(FEAT_CNT));

  assign stat_o.start_req = (op_i == OP_SAMPLE) && last_i;

  // Stores.
  logic [VALUE_W-1:0]   split_mem [NODE_CNT];
  logic [VALUE_W-1:0]   out_mem   [NODE_CNT];
  logic [VALUE_W-1:0]   feat_mem  [FEAT_CNT];
  logic [FEAT_ID_W-1:0] lvl_feat_q [TREE_DEPTH];
  logic [NODE_CNT-1:0]  leaf_q;

  // Walk registers.
  logic [CUR_W-1:0]   cur_d, cur_q;
  logic [DEP_W-1:0]   dep_d, dep_q;
  logic [NODE_AW-1:0] cur_idx;
  logic [LVL_AW-1:0]  lvl_idx;
  logic [FEAT_ID_W-1:0] cur_feat;

  logic [VALUE_W-1:0] split_rd_q, out_rd_q, feat_rd_q;
  logic               feat_oob_q;

  assign cur_idx  = cur_q[NODE_AW-1:0];
  assign lvl_idx  = (32'(dep_q) < 32'(TREE_DEPTH)) ? dep_q[LVL_AW-1:0] : '0;
  assign cur_feat = lvl_feat_q[lvl_idx];

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      split_mem[node_idx[NODE_AW-1:0]] <= node_split;
      out_mem[node_idx[NODE_AW-1:0]]   <= node_out;
    end
    split_rd_q <= split_mem[cur_idx];
    out_rd_q   <= out_mem[cur_idx];
  end

  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      feat_mem[elem_idx[FEAT_AW-1:0]] <= elem_val;
    end
    feat_rd_q  <= feat_mem[cur_feat[FEAT_AW-1:0]];
    feat_oob_q <= (32'(cur_feat) >= 32'(FEAT_CNT));
  end

  always_ff @(posedge clk_i) begin
    if (level_we) begin
      lvl_feat_q[LVL_AW'(level)] <= level_feat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_q <= '1;
    end else if (node_we) begin
      leaf_q[node_idx[NODE_AW-1:0]] <= node_leaf;
    end
  end

  // A node ends the walk when it is flagged leaf, lies beyond the stored
  // nodes, or sits on the deepest level.
  assign stat_o.walk_done = (32'(dep_q) >= 32'(TREE_DEPTH)) ||
                            (32'(cur_q) >= 32'(NODE_CNT)) ||
                            leaf_q[cur_idx];

  logic [VALUE_W-1:0] cmp_val;
  logic               go_left;

  assign cmp_val = feat_oob_q ? '0 : feat_rd_q;
  assign go_left = $signed(cmp_val) < $signed(split_rd_q);

  always_comb begin
    cur_d = cur_q;
    dep_d = dep_q;
    if (cmd_i.init) begin
      cur_d = '0;
      dep_d = '0;
    end else if (cmd_i.step) begin
      cur_d = {cur_q[CUR_W-2:0], 1'b0} + (go_left ? CUR_W'(1) : CUR_W'(2));
      dep_d = dep_q + DEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      dep_q <= '0;
    end else begin
      cur_q <= cur_d;
      dep_q <= dep_d;
    end
  end

  // Output payload register.
  logic [VALUE_W-1:0]    pred_q;
  logic [NODE_IDX_W-1:0] leaf_node_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pred_q      <= out_rd_q;
      leaf_node_q <= cur_q[NODE_IDX_W-1:0];
    end
  end

  assign out_data_o = {(OUT_TDATA_W - OUT_USED_W)'(0), leaf_node_q, pred_q};

endmodule

// ===== design/rti_checker.sv =====
// ----------------------------------------------------------------------------
// Regression tree inference checker
// Port-level assertions on the inference unit, attached by bind.
// ----------------------------------------------------------------------------
module rti_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [rti_pkg::OP_W-1:0]        s_axis_tuser,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rti_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import rti_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A last sample element starts a walk, so the next cycle refuses input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SAMPLE) && s_axis_tlast
    |=> !s_axis_tready)
    else $error("input taken while a walk should be running");

  // A new result is only loaded at the end of a walk, never while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a walk");

  // Reset leaves no result pending.
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind regression_tree_inference_unit rti_checker u_rti_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
